### hdl/dhcp_pkg.sv
`default_nettype none

package dhcp_pkg;

  localparam int unsigned ValueBytes = 4;
  localparam int unsigned NumSlots   = 4;

  localparam logic [7:0] CodePad    = 8'd0;
  localparam logic [7:0] CodeMask   = 8'd1;
  localparam logic [7:0] CodeRouter = 8'd3;
  localparam logic [7:0] CodeDns    = 8'd6;
  localparam logic [7:0] CodeServer = 8'd54;
  localparam logic [7:0] CodeEnd    = 8'd255;

  localparam logic [7:0] WantedCodeReset = 8'd53;

  localparam logic [1:0] SlotMask   = 2'd0;
  localparam logic [1:0] SlotRouter = 2'd1;
  localparam logic [1:0] SlotServer = 2'd2;
  localparam logic [1:0] SlotDns    = 2'd3;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } slot_t;

  // Maps a fixed option code to its capture slot.
  function automatic slot_t known_slot(input logic [7:0] code);
    slot_t s;
    s.hit = 1'b1;
    s.idx = SlotMask;
    unique case (code)
      CodeMask:   s.idx = SlotMask;
      CodeRouter: s.idx = SlotRouter;
      CodeServer: s.idx = SlotServer;
      CodeDns:    s.idx = SlotDns;
      default:    s.hit = 1'b0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hdl/dhcp_option_extractor.sv
// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid_i/in_ready_o | data_byte_i, last_byte_i
// result  | out       | out_valid_o/out_ready_i | captured values, flags, lengths
// config  | in        | wanted_code_we_i      | wanted_code_i
//
// One byte is accepted per cycle unless stalled; the parse state updates in the
// same cycle. The result is valid in the cycle after the last byte is accepted.
// The result register holds one word; input stalls only while it is full and
// not taken. Reset clears the parse state and sets the wanted code to 53.
`default_nettype none

module dhcp_option_extractor
  import dhcp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wanted_code_we_i,
  input  wire logic [7:0]  wanted_code_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      subnet_mask_o,
  output logic [31:0]      router_address_o,
  output logic [31:0]      server_address_o,
  output logic [31:0]      dns_address_o,
  output logic [3:0]       found_flags_o,
  output logic             wanted_found_o,
  output logic [31:0]      wanted_value_o,
  output logic [7:0]       wanted_length_o,
  output logic             end_seen_o,
  output logic             truncated_o
);

  localparam logic [1:0] PhCode  = 2'd0;
  localparam logic [1:0] PhLen   = 2'd1;
  localparam logic [1:0] PhValue = 2'd2;
  localparam logic [1:0] PhDone  = 2'd3;

  localparam logic [2:0] VidxMax  = 3'(ValueBytes);
  localparam logic [2:0] VidxLast = 3'(ValueBytes - 1);
  localparam logic [7:0] MinLen   = 8'(ValueBytes);

  logic [7:0]  wanted_code_q;
  logic [1:0]  phase_q, phase_n, phase_d;
  logic [7:0]  code_q, code_n, code_d;
  logic [7:0]  left_q, left_n, left_d;
  logic [2:0]  vidx_q, vidx_n, vidx_d;
  logic [31:0] acc_q, acc_n, acc_d;
  logic [31:0] cap_q [NumSlots];
  logic [31:0] cap_n [NumSlots];
  logic [31:0] cap_d [NumSlots];
  logic [3:0]  seen_q, seen_n, seen_d;
  logic [31:0] wcap_q, wcap_n, wcap_d;
  logic        wseen_q, wseen_n, wseen_d;
  logic [7:0]  wlen_q, wlen_n, wlen_d;
  logic        wact_q, wact_n, wact_d;
  logic        out_valid_q;
  logic        in_acc;
  logic        last_acc;
  logic [7:0]  total;
  logic [7:0]  left_dec;
  slot_t       slot;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign last_acc   = in_acc && last_byte_i;
  assign slot       = known_slot(code_q);
  assign left_dec   = (left_q != 8'd0) ? left_q - 8'd1 : left_q;

  always_comb begin
    phase_n = phase_q;
    code_n  = code_q;
    left_n  = left_q;
    vidx_n  = vidx_q;
    acc_n   = acc_q;
    cap_n   = cap_q;
    seen_n  = seen_q;
    wcap_n  = wcap_q;
    wseen_n = wseen_q;
    wlen_n  = wlen_q;
    wact_n  = wact_q;
    total   = data_byte_i;
    if (slot.hit && data_byte_i < MinLen) begin
      total = MinLen;
    end
    unique case (phase_q)
      PhCode: begin
        if (data_byte_i == CodeEnd) begin
          phase_n = PhDone;
        end else if (data_byte_i != CodePad) begin
          code_n  = data_byte_i;
          phase_n = PhLen;
        end
      end
      PhLen: begin
        wact_n = 1'b0;
        if (code_q == wanted_code_q && !wseen_q) begin
          wseen_n = 1'b1;
          wlen_n  = data_byte_i;
          wcap_n  = '0;
          wact_n  = (total != 8'd0);
        end
        acc_n   = '0;
        vidx_n  = '0;
        left_n  = total;
        phase_n = (total == 8'd0) ? PhCode : PhValue;
      end
      PhValue: begin
        if (vidx_q < VidxMax) begin
          if (slot.hit) begin
            acc_n = {acc_q[23:0], data_byte_i};
            if (vidx_q == VidxLast) begin
              cap_n[slot.idx]  = acc_n;
              seen_n[slot.idx] = 1'b1;
            end
          end
          if (wact_q && {5'd0, vidx_q} < wlen_q) begin
            wcap_n = {wcap_q[23:0], data_byte_i};
          end
          vidx_n = vidx_q + 3'd1;
        end
        left_n = left_dec;
        if (left_dec == 8'd0) begin
          phase_n = PhCode;
          wact_n  = 1'b0;
        end
      end
      PhDone: begin
        phase_n = PhDone;
      end
      default: phase_n = PhCode;
    endcase
  end

  always_comb begin
    phase_d = phase_n;
    code_d  = code_n;
    left_d  = left_n;
    vidx_d  = vidx_n;
    acc_d   = acc_n;
    cap_d   = cap_n;
    seen_d  = seen_n;
    wcap_d  = wcap_n;
    wseen_d = wseen_n;
    wlen_d  = wlen_n;
    wact_d  = wact_n;
    if (last_byte_i) begin
      phase_d = PhCode;
      code_d  = '0;
      left_d  = '0;
      vidx_d  = '0;
      acc_d   = '0;
      for (int i = 0; i < NumSlots; i++) begin
        cap_d[i] = '0;
      end
      seen_d  = '0;
      wcap_d  = '0;
      wseen_d = 1'b0;
      wlen_d  = '0;
      wact_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_code_q <= WantedCodeReset;
    end else if (wanted_code_we_i) begin
      wanted_code_q <= wanted_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhCode;
      code_q  <= '0;
      left_q  <= '0;
      vidx_q  <= '0;
      acc_q   <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        cap_q[i] <= '0;
      end
      seen_q  <= '0;
      wcap_q  <= '0;
      wseen_q <= 1'b0;
      wlen_q  <= '0;
      wact_q  <= 1'b0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      code_q  <= code_d;
      left_q  <= left_d;
      vidx_q  <= vidx_d;
      acc_q   <= acc_d;
      cap_q   <= cap_d;
      seen_q  <= seen_d;
      wcap_q  <= wcap_d;
      wseen_q <= wseen_d;
      wlen_q  <= wlen_d;
      wact_q  <= wact_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_acc) begin
      subnet_mask_o    <= cap_n[SlotMask];
      router_address_o <= cap_n[SlotRouter];
      server_address_o <= cap_n[SlotServer];
      dns_address_o    <= cap_n[SlotDns];
      found_flags_o    <= seen_n;
      wanted_found_o   <= wseen_n;
      wanted_value_o   <= wcap_n;
      wanted_length_o  <= wlen_n;
      end_seen_o       <= (phase_n == PhDone);
      truncated_o      <= (phase_n == PhLen) || (phase_n == PhValue);
    end
  end

  assign out_valid_o = out_valid_q;

  a_result_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |=> out_valid_o)
    else $error("result word missing after last byte");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |=> (phase_q == PhCode && seen_q == 4'd0 && !wseen_q && !wact_q))
    else $error("parse state not cleared after last byte");

  a_vidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vidx_q <= VidxMax)
    else $error("value index out of range");

  a_value_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhValue |-> left_q != 8'd0)
    else $error("value phase with no bytes left");

  a_wanted_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !wanted_found_o) |-> (wanted_value_o == 32'd0 && wanted_length_o == 8'd0))
    else $error("wanted value reported without wanted option");

endmodule

`default_nettype wire
